// File: src/assert_macros.svh
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check in the same cycle: whenever ante holds, cons must hold too.
`define CFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check in the next cycle: whenever ante holds, cons must hold at the next edge.
`define CFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cfd_pkg.sv
package cfd_pkg;

    // Default for the largest accepted data length
    localparam int unsigned MAX_DATA_LEN_DEF = 36;

    // Frame layout
    localparam logic [7:0] HEAD_BYTE = 8'hFF;
    localparam int unsigned HDR_BYTES = 4;
    localparam int unsigned CSUM_BYTES = 2;
    // Only frame bytes 2 (id) through 27 (last chassis data byte) are ever read
    localparam int unsigned STORE_LO = 2;
    localparam int unsigned STORE_HI = 27;
    localparam int unsigned STORE_DEPTH = STORE_HI - STORE_LO + 1;

    // Minimum data lengths per frame kind
    localparam logic [7:0] MIN_CHASSIS_LEN = 8'd24;
    localparam logic [7:0] MIN_GIMBAL_LEN = 8'd17;

    // Configuration port
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CHASSIS_ID = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GIMBAL_ID = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POSE_ID = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_ID = 8'd3;
    localparam logic [7:0] RST_CHASSIS_ID = 8'd0;
    localparam logic [7:0] RST_GIMBAL_ID = 8'd1;
    localparam logic [7:0] RST_POSE_ID = 8'd2;
    localparam logic [7:0] RST_HEARTBEAT_ID = 8'd3;

    // Pose codes and what they set
    localparam logic [7:0] POSE_CODE_FULL = 8'd3;
    localparam logic [7:0] POSE_CODE_ECO = 8'd2;
    localparam logic [7:0] POSE_CODE_COOL = 8'd1;
    localparam logic [7:0] POWER_HIGH = 8'd150;
    localparam logic [7:0] POWER_LOW = 8'd50;
    localparam logic [6:0] HEAT_LOW = 7'd10;
    localparam logic [6:0] HEAT_HIGH = 7'd90;

    // Field widths
    localparam int unsigned WORD_W = 32;
    localparam int unsigned HEAT_W = 7;

    typedef enum logic [1:0] {
        KIND_CHASSIS   = 2'd0,
        KIND_GIMBAL    = 2'd1,
        KIND_POSE      = 2'd2,
        KIND_HEARTBEAT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_HEAD = 3'b010,
        PH_DATA = 3'b100
    } t_phase;

    typedef struct packed {
        t_kind                     frame_kind;
        logic signed [WORD_W-1:0]  word_a;
        logic signed [WORD_W-1:0]  word_b;
        logic signed [WORD_W-1:0]  word_c;
        logic signed [WORD_W-1:0]  word_d;
        logic signed [WORD_W-1:0]  word_e;
        logic signed [WORD_W-1:0]  word_f;
        logic [7:0]                pose_code;
        logic [7:0]                power_limit_out;
        logic [HEAT_W-1:0]         cooling_heat_out;
        logic [7:0]                heartbeat_value;
    } t_cfd_result;

    // Little-endian word from four bytes
    function automatic logic [WORD_W-1:0] le_word(input logic [7:0] b0, input logic [7:0] b1,
                                                  input logic [7:0] b2, input logic [7:0] b3);
        return {b3, b2, b1, b0};
    endfunction

    // Two's complement negate, most negative value saturates
    function automatic logic [WORD_W-1:0] neg_sat(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] most_neg;
        most_neg = {1'b1, {(WORD_W-1){1'b0}}};
        if (w == most_neg) begin
            return ~most_neg;
        end
        return (~w) + {{(WORD_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

// File: src/cfd_ifs.sv
// Byte stream channel
interface cfd_byte_if;
    import cfd_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// Decoded frame result channel
interface cfd_result_if;
    import cfd_pkg::*;
    logic                     valid;
    logic                     ready;
    t_kind                    frame_kind;
    logic signed [WORD_W-1:0] word_a;
    logic signed [WORD_W-1:0] word_b;
    logic signed [WORD_W-1:0] word_c;
    logic signed [WORD_W-1:0] word_d;
    logic signed [WORD_W-1:0] word_e;
    logic signed [WORD_W-1:0] word_f;
    logic [7:0]               pose_code;
    logic [7:0]               power_limit_out;
    logic [HEAT_W-1:0]        cooling_heat_out;
    logic [7:0]               heartbeat_value;

    modport source (output valid, output frame_kind, output word_a, output word_b,
                    output word_c, output word_d, output word_e, output word_f,
                    output pose_code, output power_limit_out, output cooling_heat_out,
                    output heartbeat_value, input ready);
    modport sink (input valid, input frame_kind, input word_a, input word_b,
                  input word_c, input word_d, input word_e, input word_f,
                  input pose_code, input power_limit_out, input cooling_heat_out,
                  input heartbeat_value, output ready);
endinterface

// File: src/command_frame_deframer.sv
// Command frame deframer.
// i_byte carries one received byte per item; frames are 0xFF, address, id,
// length, data bytes and two checksum bytes (not checked). o_result
// carries one decoded item for each complete chassis, gimbal, pose or
// heartbeat frame whose id matches the id registers (i_cfg_we/idx/data).
// Frames with a too-long length, too short for their kind or with an unknown
// id give nothing. A pose frame with a known code also updates the held power limit and heat.
// Throughput: one byte per cycle while i_byte.ready is high. The frame is
// decoded in the cycle its last byte is accepted and the result sits in the
// output register on the next cycle.
// The output register is the only buffer: while it holds a result that the
// receiver has not taken, i_byte.ready is low; once taken, or if empty, a
// byte is taken every cycle, including in the cycle the result is taken.
// Reset (synchronous, active low) restarts the header hunt, clears the
// output valid, power limit and heat, and loads the default id registers.
`include "assert_macros.svh"
module command_frame_deframer #(
    parameter int unsigned MAX_DATA_LEN = cfd_pkg::MAX_DATA_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cfd_byte_if.sink                       i_byte,
    cfd_result_if.source                   o_result
);
    import cfd_pkg::*;

    // Byte counter holds up to the full frame length
    localparam int unsigned CNT_W = $clog2(MAX_DATA_LEN + HDR_BYTES + CSUM_BYTES + 1);
    localparam logic [8:0] LEN_MAX9 = 9'(MAX_DATA_LEN);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_HDR = CNT_W'(HDR_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DATA_LEN + HDR_BYTES + CSUM_BYTES - 1);

    // Id registers
    logic [7:0] r_chassis_id, r_gimbal_id, r_pose_id, r_heartbeat_id;

    // Parser state
    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [7:0]        r_len, n_len;
    logic [7:0]        r_store [STORE_DEPTH];
    logic [7:0]        r_power_limit, n_power_limit;
    logic [HEAT_W-1:0] r_cooling_heat, n_cooling_heat;

    // Output register
    logic        r_out_valid;
    t_cfd_result r_out, n_out;

    logic       w_in_ready, w_accept, w_store_en, w_frame_end, w_fire;
    logic       w_res_valid, w_pose_upd;
    logic       w_hit_c, w_hit_g, w_hit_p, w_hit_h;
    logic [7:0] w_byte, w_id, w_code;
    logic [8:0] w_end_cnt;

    assign w_byte = i_byte.in_byte;
    assign w_in_ready = !r_out_valid || o_result.ready;
    assign w_accept = i_byte.valid && w_in_ready;
    assign i_byte.ready = w_in_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chassis_id <= RST_CHASSIS_ID;
            r_gimbal_id <= RST_GIMBAL_ID;
            r_pose_id <= RST_POSE_ID;
            r_heartbeat_id <= RST_HEARTBEAT_ID;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHASSIS_ID:   r_chassis_id <= i_cfg_data;
                CFG_GIMBAL_ID:    r_gimbal_id <= i_cfg_data;
                CFG_POSE_ID:      r_pose_id <= i_cfg_data;
                CFG_HEARTBEAT_ID: r_heartbeat_id <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame end: count after this byte reaches header + data + checksum
    assign w_end_cnt = {1'b0, r_len} + 9'(HDR_BYTES + CSUM_BYTES);
    assign w_frame_end = (9'(r_count + CNT_ONE) >= w_end_cnt);

    // Parser state machine
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_len = r_len;
        w_store_en = 1'b0;
        w_fire = 1'b0;
        case (r_phase)
            PH_HEAD: begin
                w_store_en = 1'b1;
                n_count = r_count + CNT_ONE;
                if (n_count >= CNT_HDR) begin
                    n_len = w_byte;
                    n_phase = ({1'b0, w_byte} > LEN_MAX9) ? PH_WAIT : PH_DATA;
                end
            end
            PH_DATA: begin
                w_store_en = 1'b1;
                n_count = r_count + CNT_ONE;
                if (w_frame_end) begin
                    w_fire = 1'b1;
                    n_phase = PH_WAIT;
                end
            end
            default: begin
                n_phase = PH_WAIT;
                if (w_byte == HEAD_BYTE) begin
                    n_count = CNT_ONE;
                    n_phase = PH_HEAD;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_count <= '0;
            r_len <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_len <= n_len;
        end
    end

    // Keep only the frame bytes that decoding reads
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (w_accept && w_store_en && (32'(r_count) == STORE_LO + i)) begin
                r_store[i] <= w_byte;
            end
        end
    end

    // Id match, first hit wins in the order chassis, gimbal, pose, heartbeat
    assign w_id = r_store[0];
    assign w_code = r_store[4 - STORE_LO];
    assign w_hit_c = (w_id == r_chassis_id);
    assign w_hit_g = !w_hit_c && (w_id == r_gimbal_id);
    assign w_hit_p = !w_hit_c && !w_hit_g && (w_id == r_pose_id);
    assign w_hit_h = !w_hit_c && !w_hit_g && !w_hit_p && (w_id == r_heartbeat_id);

    assign w_res_valid = w_accept && w_fire &&
                         ((w_hit_c && (r_len >= MIN_CHASSIS_LEN)) ||
                          (w_hit_g && (r_len >= MIN_GIMBAL_LEN)) ||
                          ((w_hit_p || w_hit_h) && (r_len != 8'd0)));
    assign w_pose_upd = w_res_valid && w_hit_p;

    // Pose code sets power limit and heat
    always_comb begin
        n_power_limit = r_power_limit;
        n_cooling_heat = r_cooling_heat;
        if (w_pose_upd) begin
            case (w_code)
                POSE_CODE_FULL: begin
                    n_power_limit = POWER_HIGH;
                    n_cooling_heat = HEAT_LOW;
                end
                POSE_CODE_ECO: begin
                    n_power_limit = POWER_LOW;
                    n_cooling_heat = HEAT_LOW;
                end
                POSE_CODE_COOL: begin
                    n_power_limit = POWER_LOW;
                    n_cooling_heat = HEAT_HIGH;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_limit <= '0;
            r_cooling_heat <= '0;
        end else begin
            r_power_limit <= n_power_limit;
            r_cooling_heat <= n_cooling_heat;
        end
    end

    // Result assembly; store index is frame index minus STORE_LO
    always_comb begin
        n_out = '0;
        n_out.power_limit_out = n_power_limit;
        n_out.cooling_heat_out = n_cooling_heat;
        if (w_hit_c) begin
            n_out.frame_kind = KIND_CHASSIS;
            n_out.word_a = $signed(le_word(r_store[2], r_store[3], r_store[4], r_store[5]));
            n_out.word_b = $signed(le_word(r_store[6], r_store[7], r_store[8], r_store[9]));
            n_out.word_c = $signed(le_word(r_store[10], r_store[11], r_store[12],
                                           r_store[13]));
            n_out.word_d = $signed(le_word(r_store[14], r_store[15], r_store[16],
                                           r_store[17]));
            n_out.word_e = $signed(le_word(r_store[18], r_store[19], r_store[20],
                                           r_store[21]));
            n_out.word_f = $signed(le_word(r_store[22], r_store[23], r_store[24],
                                           r_store[25]));
        end else if (w_hit_g) begin
            n_out.frame_kind = KIND_GIMBAL;
            n_out.word_a = $signed(neg_sat(le_word(r_store[3], r_store[4], r_store[5],
                                                   r_store[6])));
            n_out.word_b = $signed(le_word(r_store[7], r_store[8], r_store[9], r_store[10]));
            n_out.word_c = $signed(le_word(r_store[11], r_store[12], r_store[13],
                                           r_store[14]));
            n_out.word_d = $signed(le_word(r_store[15], r_store[16], r_store[17],
                                           r_store[18]));
        end else if (w_hit_p) begin
            n_out.frame_kind = KIND_POSE;
            n_out.pose_code = w_code;
        end else begin
            n_out.frame_kind = KIND_HEARTBEAT;
            n_out.heartbeat_value = w_code;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.frame_kind = r_out.frame_kind;
    assign o_result.word_a = r_out.word_a;
    assign o_result.word_b = r_out.word_b;
    assign o_result.word_c = r_out.word_c;
    assign o_result.word_d = r_out.word_d;
    assign o_result.word_e = r_out.word_e;
    assign o_result.word_f = r_out.word_f;
    assign o_result.pose_code = r_out.pose_code;
    assign o_result.power_limit_out = r_out.power_limit_out;
    assign o_result.cooling_heat_out = r_out.cooling_heat_out;
    assign o_result.heartbeat_value = r_out.heartbeat_value;

    // Checks
    `CFD_ASSERT_NEXT(a_hunt_stays, i_clk, i_rst_n, w_accept && (r_phase == PH_WAIT) && (w_byte != HEAD_BYTE), r_phase == PH_WAIT, "non-header byte left the hunt")
    `CFD_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, r_phase == PH_DATA, r_count <= CNT_LAST, "byte count ran past the longest frame")
    `CFD_ASSERT_NEXT(a_pose_state, i_clk, i_rst_n, !w_pose_upd, $stable(r_power_limit) && $stable(r_cooling_heat), "power or heat changed without a pose frame")
    `CFD_ASSERT_NEXT(a_result_source, i_clk, i_rst_n, !r_out_valid && !w_fire, !r_out_valid, "result appeared without a frame end")

endmodule
